>>> rtl/core/b64d_pkg.sv
// Shared types and constants for the base64 decoder.
// Holds the alphabet lookup, result status codes and the queued job format.
// No dependencies.
package b64d_pkg;

   localparam logic [7:0] PAD_CODE = 8'h3D;

   typedef enum logic [1:0] {
      ST_DATA   = 2'd0,
      ST_SYMBOL = 2'd1,
      ST_LENGTH = 2'd2
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   // one queued job: one to three result beats
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  count;
      status_type  status;
      logic        eot;
   } job_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = '0;
      if (c inside {[8'h41:8'h5A]}) begin
         s.value = 6'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7A]}) begin
         s.value = 6'(c - 8'h61 + 8'd26);
      end else if (c inside {[8'h30:8'h39]}) begin
         s.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         s.value = 6'd62;
      end else if (c == 8'h2F) begin
         s.value = 6'd63;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

>>> rtl/core/b64d_front.sv
// Front end: accepts characters, checks them and tracks quartet state.
// Pushes one job per completed quartet or error. Uses b64d_pkg.
module b64d_front import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_code,
   input  logic       end_of_text,
   output logic       push,
   output job_type    job
);

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] accum_ff, accum_in;
   logic        pad_pending_ff, pad_pending_in;
   logic        discard_ff, discard_in;

   sextet_type sx;
   logic       is_pad;
   logic       sym_bad;

   assign sx      = sextet_of(char_code);
   assign is_pad  = (char_code == PAD_CODE);
   assign sym_bad = (!is_pad && !sx.valid) || (is_pad && pos_ff < 2'd2)
                 || (pos_ff == 2'd3 && pad_pending_ff && !is_pad);

   always_comb begin
      pos_in         = pos_ff;
      accum_in       = accum_ff;
      pad_pending_in = pad_pending_ff;
      discard_in     = discard_ff;
      push           = 1'b0;
      job            = '0;
      job.eot        = end_of_text;
      job.count      = 2'd1;
      if (accept) begin
         if (discard_ff) begin
            if (end_of_text) begin
               pos_in         = '0;
               accum_in       = '0;
               pad_pending_in = 1'b0;
               discard_in     = 1'b0;
            end
         end else if (sym_bad || (pos_ff == 2'd3 && (is_pad || pad_pending_ff)
                                  && !end_of_text)
                      || (pos_ff != 2'd3 && end_of_text)) begin
            push           = 1'b1;
            job.status     = (sym_bad || pos_ff == 2'd3) ? ST_SYMBOL : ST_LENGTH;
            pos_in         = '0;
            accum_in       = '0;
            pad_pending_in = 1'b0;
            discard_in     = !end_of_text;
         end else if (pos_ff != 2'd3) begin
            accum_in = {accum_ff[11:0], is_pad ? 6'd0 : sx.value};
            pos_in   = pos_ff + 2'd1;
            if (is_pad) begin
               pad_pending_in = 1'b1;
            end
         end else begin
            push       = 1'b1;
            job.status = ST_DATA;
            job.bits   = {accum_ff, is_pad ? 6'd0 : sx.value};
            job.count  = pad_pending_ff ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
            pos_in         = '0;
            accum_in       = '0;
            pad_pending_in = 1'b0;
            discard_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         accum_ff       <= '0;
         pad_pending_ff <= 1'b0;
         discard_ff     <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         accum_ff       <= accum_in;
         pad_pending_ff <= pad_pending_in;
         discard_ff     <= discard_in;
      end
   end

endmodule

>>> rtl/core/b64d_queue.sv
// Short job queue between front and back ends.
// Circular buffer of job_type entries. Uses b64d_pkg.
module b64d_queue import b64d_pkg::*; #(
   parameter int DEPTH_LOG2 = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head_job
);

   localparam int DEPTH = 1 << DEPTH_LOG2;

   job_type             entry_ff [DEPTH];
   logic [DEPTH_LOG2:0] wr_ff, wr_in;
   logic [DEPTH_LOG2:0] rd_ff, rd_in;

   assign not_empty = (wr_ff != rd_ff);
   assign full      = (wr_ff[DEPTH_LOG2] != rd_ff[DEPTH_LOG2])
                   && (wr_ff[DEPTH_LOG2-1:0] == rd_ff[DEPTH_LOG2-1:0]);
   assign head_job  = entry_ff[rd_ff[DEPTH_LOG2-1:0]];
   assign wr_in     = wr_ff + (DEPTH_LOG2+1)'(push);
   assign rd_in     = rd_ff + (DEPTH_LOG2+1)'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff[DEPTH_LOG2-1:0]] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

endmodule

>>> rtl/core/b64d_back.sv
// Back end: unpacks queued jobs into result beats, one per cycle while rsp_tready allows.
// Drives the registered result channel. Uses b64d_pkg.
module b64d_back import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [1:0] rsp_tuser,
   output logic       rsp_tlast
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;
   logic       load;
   logic       final_beat;

   assign load       = head_valid && (!valid_ff || rsp_tready);
   assign final_beat = (idx_ff == head_job.count - 2'd1);
   assign pop        = load && final_beat;

   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff && !rsp_tready;
      byte_in   = byte_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in  = 1'b1;
         byte_in   = head_job.bits[5'd23 - {idx_ff, 3'b000} -: 8];
         status_in = head_job.status;
         last_in   = head_job.eot && final_beat;
         idx_in    = final_beat ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> rtl/core/base64_decoder_unit.sv
// Channel | dir | beat contents
// req     | in  | tdata[7:0] char_code, tlast end_of_text
// rsp     | out | tdata[7:0] out_byte, tuser[1:0] status, tlast last
//
// One character per cycle in while the job queue has room; result beats leave one per cycle from a register
// while rsp_tready is high. Three bytes per quartet fit the rate; the job queue absorbs bursts and stalls.
// req_tready drops only while the job queue is full.
// The fourth character's job is written into the job queue, then its first byte into the output register.
// Synchronous reset clears quartet state, queue pointers and output valid.
// Top level: front end, job queue, back end. Uses b64d_pkg.
module base64_decoder_unit import b64d_pkg::*; #(
   parameter int QUEUE_DEPTH_LOG2 = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] status
   output logic       rsp_tlast
);

   logic    accept;
   logic    push;
   logic    pop;
   logic    full;
   logic    not_empty;
   job_type push_job;
   job_type head_job;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_tdata),
      .end_of_text (req_tlast),
      .push        (push),
      .job         (push_job)
   );

   b64d_queue #(
      .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_job  (head_job)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> rtl/core/b64d_checker.sv
// Port-level checks for base64_decoder_unit, bound to the top level.
// Uses b64d_pkg status codes.
module b64d_checker import b64d_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat withdrawn while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DATA |-> rsp_tdata == 8'd0)
      else $error("error beat carries non-zero byte");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_DATA || rsp_tuser == ST_SYMBOL
                      || rsp_tuser == ST_LENGTH))
      else $error("undefined status");

   a_len_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_LENGTH |-> rsp_tlast)
      else $error("length error not at end of text");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind base64_decoder_unit b64d_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> bench/tb.sv
// Self-checking bench for base64_decoder_unit: directed table, then random texts.
// Predicts result beats from its own decoder state or the directed table and checks each beat in order.
// Depends on b64d_pkg and the RTL top level.
module tb;
   import b64d_pkg::*;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam int QUIET_LIMIT   = 1000;
   localparam int HOLD_CYCLES   = 60;
   localparam int PHASE_CHARS   = 60;
   localparam int DIRECTED_ROWS = 25;

   typedef struct {
      logic [7:0] data;
      status_type status;
      logic       last;
   } decoded_beat_type;

   typedef struct {
      logic [7:0] c;
      logic       eot;
      bit         typed;
      logic [7:0] data;
      status_type status;
      logic       last;
   } table_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;  // [7:0] char_code
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] out_byte
   logic [1:0] rsp_tuser;          // [1:0] status
   logic       rsp_tlast;

   base64_decoder_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder state of the predictor
   logic [1:0]  q_pos;
   logic [17:0] q_acc;
   logic        q_pad;
   logic        skipping;

   decoded_beat_type fresh[$];
   decoded_beat_type pending_bytes[$];
   decoded_beat_type want;
   logic [7:0]       text_chars[$];

   int  send_idle  = 0;
   int  recv_stall = 0;
   bit  hold_request = 0;
   int  hold_left = 0;
   int  quiet = 0;
   int  errors = 0;
   int  beats_checked = 0;
   int  chars_sent = 0;
   int  texts_sent = 0;

   table_row_type directed [0:DIRECTED_ROWS-1] = '{
      '{"/", 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{"/", 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{"/", 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{"/", 1'b1, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{PAD_CODE, 1'b1, 1'b1, 8'h00, ST_SYMBOL, 1'b1},
      '{8'hFF, 1'b1, 1'b1, 8'h00, ST_SYMBOL, 1'b1},
      '{8'h80, 1'b0, 1'b1, 8'h00, ST_SYMBOL, 1'b0},
      '{"A", 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{"z", 1'b1, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{"A", 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{"B", 1'b1, 1'b1, 8'h00, ST_LENGTH, 1'b1},
      '{"A", 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{PAD_CODE, 1'b1, 1'b1, 8'h00, ST_SYMBOL, 1'b1},
      '{"Q", 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{"9", 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{PAD_CODE, 1'b1, 1'b1, 8'h00, ST_LENGTH, 1'b1},
      '{"Q", 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{"Q", 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{PAD_CODE, 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{PAD_CODE, 1'b1, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{"A", 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{"B", 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{PAD_CODE, 1'b0, 1'b0, 8'h00, ST_DATA,   1'b0},
      '{"C", 1'b0, 1'b1, 8'h00, ST_SYMBOL, 1'b0},
      '{"0", 1'b1, 1'b0, 8'h00, ST_DATA,   1'b0}
   };

   function automatic void clear_quartet();
      q_pos = 2'd0;
      q_acc = 18'd0;
      q_pad = 1'b0;
   endfunction

   function automatic void flag_error(input status_type st, input logic eot);
      clear_quartet();
      skipping = !eot;
      fresh.push_back(decoded_beat_type'{8'h00, st, eot});
   endfunction

   // returns 0 when the character is swallowed by the discard state
   function automatic bit decode_char(input logic [7:0] c, input logic eot);
      logic        is_pad;
      logic        known;
      logic [5:0]  v;
      logic [23:0] full;
      int          pads;
      is_pad = (c == PAD_CODE);
      known = 1'b1;
      v = 6'd0;
      if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd25) v = 6'(c - CH_UPPER_A);
      else if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd25) v = 6'(c - CH_LOWER_A + 8'd26);
      else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_0 + 8'd9) v = 6'(c - CH_DIGIT_0 + 8'd52);
      else if (c == CH_PLUS) v = 6'd62;
      else if (c == CH_SLASH) v = 6'd63;
      else known = 1'b0;
      fresh.delete();
      if (skipping) begin
         if (eot) begin
            clear_quartet();
            skipping = 1'b0;
         end
         return 1'b0;
      end
      if ((!is_pad && !known) || (is_pad && q_pos < 2'd2) ||
          (q_pos == 2'd3 && q_pad && !is_pad)) begin
         flag_error(ST_SYMBOL, eot);
         return 1'b1;
      end
      if (q_pos != 2'd3) begin
         if (eot) begin
            flag_error(ST_LENGTH, eot);
            return 1'b1;
         end
         if (is_pad) begin
            q_pad = 1'b1;
            v = 6'd0;
         end
         q_acc = {q_acc[11:0], v};
         q_pos = q_pos + 2'd1;
         return 1'b1;
      end
      pads = int'(is_pad) + int'(q_pad);
      if (pads != 0 && !eot) begin
         flag_error(ST_SYMBOL, eot);
         return 1'b1;
      end
      full = {q_acc, is_pad ? 6'd0 : v};
      for (int k = 0; k < 3 - pads; k++) begin
         fresh.push_back(decoded_beat_type'{full[23 - 8*k -: 8], ST_DATA,
                                            eot && (k == 2 - pads)});
      end
      clear_quartet();
      skipping = 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      if (s < 6'd26) return CH_UPPER_A + 8'(s);
      if (s < 6'd52) return CH_LOWER_A + 8'(s - 6'd26);
      if (s < 6'd62) return CH_DIGIT_0 + 8'(s - 6'd52);
      return (s == 6'd62) ? CH_PLUS : CH_SLASH;
   endfunction

   // mostly well-formed texts, some broken ones, some pure noise
   task automatic build_text();
      int kind;
      int quartets;
      int pads;
      int cut;
      kind = $urandom_range(99);
      text_chars.delete();
      if (kind < 10) begin
         repeat ($urandom_range(1, 6)) text_chars.push_back(8'($urandom_range(255)));
      end else begin
         quartets = $urandom_range(1, 4);
         repeat (4 * quartets) text_chars.push_back(sextet_char(6'($urandom_range(63))));
         pads = ($urandom_range(1) == 1) ? $urandom_range(2) : 0;
         for (int i = 0; i < pads; i++) text_chars[text_chars.size() - 1 - i] = PAD_CODE;
         if (kind >= 85) begin
            case ($urandom_range(2))
               0: text_chars[$urandom_range(text_chars.size() - 1)] = 8'($urandom_range(255));
               1: text_chars[$urandom_range(text_chars.size() - 1)] = PAD_CODE;
               default: begin
                  cut = $urandom_range(1, 3);
                  repeat (cut) text_chars.delete(text_chars.size() - 1);
                  if (text_chars.size() == 0) text_chars.push_back(sextet_char(6'd0));
               end
            endcase
         end
      end
   endtask

   // offer one character; returns at the edge where it is accepted
   task automatic send_char(input logic [7:0] c, input logic eot);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   // receiver
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   // result checker and quiet-cycle counter
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
      else quiet = quiet + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (pending_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat byte %02h status %0d last %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.data) begin
               errors++;
               $display("%0t: out_byte expected %02h actual %02h", $time, want.data, rsp_tdata);
            end
            if (rsp_tuser !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
            end
            if (rsp_tlast !== want.last) begin
               errors++;
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_tlast);
            end
         end
      end
   end

   // watchdog
   initial begin
      while (quiet < QUIET_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int  phase_chars;
      bit  hold_done;
      logic eot;
      clear_quartet();
      skipping = 1'b0;
      hold_done = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_char(directed[r].c, directed[r].eot);
         void'(decode_char(directed[r].c, directed[r].eot));
         if (directed[r].typed) begin
            pending_bytes.push_back(decoded_beat_type'{directed[r].data, directed[r].status,
                                                       directed[r].last});
         end else begin
            foreach (fresh[i]) pending_bytes.push_back(fresh[i]);
         end
      end
      wait_drain();
      texts_sent = 9;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 48; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 48; end
            default: begin send_idle = 19; recv_stall = 19; end
         endcase
         phase_chars = 0;
         while (phase_chars < PHASE_CHARS) begin
            build_text();
            // long output hold-off while characters keep coming
            if (phase == 0 && !hold_done && phase_chars >= 10) begin
               hold_request = 1;
               hold_done = 1;
            end
            foreach (text_chars[i]) begin
               eot = (i == text_chars.size() - 1);
               send_char(text_chars[i], eot);
               if (decode_char(text_chars[i], eot)) phase_chars++;
               foreach (fresh[j]) pending_bytes.push_back(fresh[j]);
            end
            texts_sent++;
         end
         wait_drain();
      end

      repeat (20) @(posedge clock);
      $display("Sent %0d characters in %0d texts under four idle/stall mixes;", chars_sent,
               texts_sent);
      $display("checked %0d result beats, %0d field errors.", beats_checked, errors);
      if (errors == 0 && pending_bytes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_front.sv
rtl/core/b64d_queue.sv
rtl/core/b64d_back.sv
rtl/core/base64_decoder_unit.sv
rtl/core/b64d_checker.sv
bench/tb.sv
